>>> design/cma_pkg.sv
// shared types and constants of the centered moving average
package cma_pkg;

   localparam int CFG_W             = 5;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam logic [CFG_W-1:0] HALF_WINDOW_RESET = 5'd2;
   localparam logic REG_HALF_WINDOW = 1'b0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TRIM,
      S_DROP,
      S_DIVIDE,
      S_EMIT,
      S_NEXT,
      S_CLEAR
   } cma_state_type;

   typedef struct packed {
      logic accept;
      logic rd_issue;
      logic drop;
      logic div_start;
      logic load_out;
      logic flushing;
      logic flush_begin;
      logic flush_step;
      logic k_dec;
      logic clear;
   } cma_cmd_type;

   typedef struct packed {
      logic over_limit;
      logic seen_gt_p;
      logic last;
      logic m_zero;
      logic k_zero;
      logic div_done;
      logic out_free;
   } cma_status_type;

endpackage

>>> design/cma_ctrl.sv
// controller state machine of the centered moving average
module cma_ctrl
   import cma_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  cma_status_type status,
   output cma_cmd_type    cmd
);

   cma_state_type state_ff, state_in;
   logic          flush_ff, flush_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flush_ff <= flush_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_TRIM;
         end
         S_TRIM: begin
            if (status.over_limit) state_in = S_DROP;
            else if (flush_ff || status.seen_gt_p) state_in = S_DIVIDE;
            else state_in = S_NEXT;
         end
         S_DROP:   state_in = S_TRIM;
         S_DIVIDE: begin
            if (status.div_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) state_in = S_NEXT;
         end
         S_NEXT: begin
            if (!status.last) state_in = S_IDLE;
            else if (flush_ff) state_in = status.k_zero ? S_CLEAR : S_TRIM;
            else state_in = status.m_zero ? S_CLEAR : S_TRIM;
         end
         S_CLEAR:  state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      flush_in = flush_ff;
      if (state_ff == S_CLEAR) flush_in = 1'b0;
      else if (state_ff == S_NEXT && status.last && !flush_ff && !status.m_zero)
         flush_in = 1'b1;
   end

   always_comb begin
      cmd          = '0;
      cmd.flushing = flush_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_TRIM: begin
            if (status.over_limit) cmd.rd_issue = 1'b1;
            else if (flush_ff || status.seen_gt_p) cmd.div_start = 1'b1;
         end
         S_DROP:   cmd.drop = 1'b1;
         S_DIVIDE: begin
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.k_dec    = flush_ff;
            end
         end
         S_NEXT: begin
            if (status.last) begin
               if (flush_ff) cmd.flush_step = !status.k_zero;
               else cmd.flush_begin = !status.m_zero;
            end
         end
         S_CLEAR:  cmd.clear = 1'b1;
         default:  cmd = '0;
      endcase
   end

endmodule

>>> design/cma_datapath.sv
// sample ring, window sums, serial divider and output register
module cma_datapath
   import cma_pkg::*;
#(
   parameter int MAX_HALF_WINDOW = 31,
   parameter int SAMPLE_BITS     = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cma_cmd_type            cmd,
   output cma_status_type         status,
   input  logic [CFG_W-1:0]       half_window,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_record_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_smoothed,
   output logic                   rsp_run_end
);

   localparam int RING = 2 * MAX_HALF_WINDOW + 2;
   localparam int AW   = $clog2(RING);
   localparam int CW   = $clog2(RING + 1);
   localparam int EW   = CW + 1;
   localparam int PW   = CFG_W;
   localparam int LW   = PW + 1;
   localparam int XW   = CW + PW;
   localparam int TW   = SAMPLE_BITS + CW;
   localparam int NW   = TW + 1;
   localparam int DW   = CW + 1;
   localparam int NCW  = $clog2(NW + 1);

   logic [SAMPLE_BITS-1:0] sample_ring_ff [RING];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [TW-1:0]          total_ff;
   logic [CW-1:0]          members_ff;
   logic [CW-1:0]          seen_ff;
   logic [AW-1:0]          head_ff;
   logic [PW-1:0]          p_ff;
   logic [PW-1:0]          k_ff;
   logic [LW-1:0]          limit_ff;
   logic                   last_ff;
   logic [NW-1:0]          num_ff;
   logic [DW-1:0]          rem_ff;
   logic [DW-1:0]          den_ff;
   logic [NCW-1:0]         cnt_ff;
   logic                   out_valid_ff;
   logic [SAMPLE_BITS-1:0] smoothed_ff;
   logic                   run_end_ff;

   logic [PW-1:0] p_new;
   logic [PW-1:0] m_val;
   logic [EW-1:0] head_x, members_x, drop_x;
   logic [AW-1:0] drop_addr;
   logic [DW:0]   trial;
   logic          trial_ge;
   logic [AW-1:0] head_inc;

   always_comb begin
      if (int'(half_window) > MAX_HALF_WINDOW) p_new = PW'(MAX_HALF_WINDOW);
      else p_new = half_window;
   end

   assign m_val = (XW'(seen_ff) < XW'(p_ff)) ? PW'(seen_ff) : p_ff;

   always_comb begin
      head_x    = EW'(head_ff);
      members_x = EW'(members_ff);
      if (head_x >= members_x) drop_x = head_x - members_x;
      else drop_x = head_x + EW'(RING) - members_x;
      drop_addr = AW'(drop_x);
   end

   assign head_inc = (int'(head_ff) == RING - 1) ? '0 : head_ff + AW'(1);
   assign trial    = {rem_ff, num_ff[NW-1]};
   assign trial_ge = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept) sample_ring_ff[head_ff] <= req_sample;
      if (cmd.rd_issue) rd_data_ff <= sample_ring_ff[drop_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         members_ff <= '0;
         seen_ff    <= '0;
         head_ff    <= '0;
      end else if (cmd.accept) begin
         total_ff   <= total_ff + TW'(req_sample);
         members_ff <= members_ff + CW'(1);
         if (seen_ff != '1) seen_ff <= seen_ff + CW'(1);
         head_ff    <= head_inc;
      end else if (cmd.drop) begin
         total_ff   <= total_ff - TW'(rd_data_ff);
         members_ff <= members_ff - CW'(1);
      end else if (cmd.clear) begin
         total_ff   <= '0;
         members_ff <= '0;
         seen_ff    <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         p_ff     <= p_new;
         last_ff  <= req_record_end;
         limit_ff <= {p_new, 1'b1};
      end else if (cmd.flush_begin) begin
         k_ff     <= m_val;
         limit_ff <= LW'(m_val) + LW'(p_ff);
      end else if (cmd.flush_step) begin
         limit_ff <= LW'(k_ff) + LW'(p_ff);
      end else if (cmd.k_dec) begin
         k_ff     <= k_ff - PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff <= NCW'(NW);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - NCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff <= {total_ff, 1'b0} + NW'(members_ff);
         den_ff <= {members_ff, 1'b0};
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         num_ff <= {num_ff[NW-2:0], trial_ge};
         rem_ff <= trial_ge ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         smoothed_ff <= num_ff[SAMPLE_BITS-1:0];
         run_end_ff  <= last_ff && (cmd.flushing ? (k_ff == PW'(1)) : (m_val == '0));
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_smoothed = smoothed_ff;
   assign rsp_run_end  = run_end_ff;

   always_comb begin
      status            = '0;
      status.over_limit = XW'(members_ff) > XW'(limit_ff);
      status.seen_gt_p  = XW'(seen_ff) > XW'(p_ff);
      status.last       = last_ff;
      status.m_zero     = m_val == '0;
      status.k_zero     = k_ff == '0;
      status.div_done   = cnt_ff == '0;
      status.out_free   = !out_valid_ff || rsp_ready;
   end

endmodule

>>> design/centered_moving_average.sv
// top level of the centered moving average over a sample record
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   req_sample, req_record_end
//   rsp_      out        rsp_valid / rsp_ready   rsp_smoothed, rsp_run_end
//   csr_      in         apb write, pready = 1   half_window at byte address 0
//
// a sample with an output passes accept, trim check, serial divide, emit and step; each sample
// dropped adds a ring read and a drop; a sample with no output yet passes accept, trim check and step
// each flush output passes trim check, serial divide, emit and step
// one request is worked at a time; a request is taken while a result waits at the output
// the last request of a record yields up to half_window+1 outputs; the ring needs no clearing
// reset is synchronous and active high; a stalled rsp_ready holds the controller in emit
module centered_moving_average
   import cma_pkg::*;
#(
   parameter int MAX_HALF_WINDOW = 31,
   parameter int SAMPLE_BITS     = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_record_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_smoothed,
   output logic                   rsp_run_end,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [CFG_W-1:0] half_window_ff;
   logic             csr_wr;
   cma_cmd_type      ctl_cmd;
   cma_status_type   dp_status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_window_ff <= HALF_WINDOW_RESET;
      end else if (csr_wr && csr_paddr[2] == REG_HALF_WINDOW) begin
         half_window_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_HALF_WINDOW) ?
                       CSR_DATA_W'(half_window_ff) : '0;

   cma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctl_cmd)
   );

   cma_datapath #(
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctl_cmd),
      .status         (dp_status),
      .half_window    (half_window_ff),
      .req_sample     (req_sample),
      .req_record_end (req_record_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_smoothed   (rsp_smoothed),
      .rsp_run_end    (rsp_run_end)
   );

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a waiting result");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.div_start |=> !dp_status.div_done)
      else $error("divider idle after start");

   a_drop_after_read: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.drop |-> $past(ctl_cmd.rd_issue))
      else $error("window drop without ring read");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

endmodule
